// ===== design/sfp_pkg.sv =====
// shared types and constants for the scale frame parser
`default_nettype none

package sfp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic               frame_kind;
    logic [1:0]         stability;
    logic               gross_net;
    logic               weight_unit;
    logic [7:0]         device_number;
    logic signed [27:0] weight_value;
    logic [2:0]         point_position;
  } out_item_t;

  typedef struct packed {
    logic       go;
    logic       last;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic [4:0][7:0] head;
    logic [7:0]      b6;
    logic [7:0]      b18;
    logic [7:0]      b19;
  } fields_t;

  typedef struct packed {
    logic [26:0] acc;
    logic        minus;
    logic [2:0]  point;
  } weight_t;

  localparam int unsigned ACC_W = 27;
  localparam int unsigned WGT_W = 28;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_LOW_G = 8'h67;
  localparam logic [7:0] CH_LOW_K = 8'h6B;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic       KIND_REPORT   = 1'b0;
  localparam logic       KIND_SETTINGS = 1'b1;
  localparam logic [1:0] STAB_UNSTABLE = 2'd0;
  localparam logic [1:0] STAB_STABLE   = 2'd1;
  localparam logic [1:0] STAB_OVERLOAD = 2'd2;
  localparam logic       GN_GROSS      = 1'b0;
  localparam logic       GN_NET        = 1'b1;
  localparam logic       UNIT_KG       = 1'b0;
  localparam logic       UNIT_TON      = 1'b1;

  localparam int unsigned POS_DEVICE  = 6;
  localparam int unsigned POS_WFIRST  = 9;
  localparam int unsigned POS_WLAST   = 16;
  localparam int unsigned POS_UNIT_HI = 18;
  localparam int unsigned POS_UNIT_LO = 19;
  localparam int unsigned HEAD_LEN    = 5;

endpackage

`default_nettype wire

// ===== design/sfp_field_capture.sv =====
// byte position counter and capture of the fixed-position frame bytes
`default_nettype none

module sfp_field_capture #(
  parameter int unsigned MAX_FRAME = 64,
  parameter int unsigned PW        = 7
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sfp_pkg::step_t  step,
  output logic [PW-1:0]        pos,
  output sfp_pkg::fields_t     view
);

  logic [PW-1:0]    pos_r;
  logic [PW-1:0]    pos_nxt;
  sfp_pkg::fields_t fld_r;
  sfp_pkg::fields_t fld_nxt;

  always_comb begin
    view = fld_r;
    if (step.go) begin
      for (int i = 0; i < sfp_pkg::HEAD_LEN; i++) begin
        if (pos_r == PW'(i)) begin
          view.head[i] = step.data;
        end
      end
      if (pos_r == PW'(sfp_pkg::POS_DEVICE)) begin
        view.b6 = step.data;
      end
      if (pos_r == PW'(sfp_pkg::POS_UNIT_HI)) begin
        view.b18 = step.data;
      end
      if (pos_r == PW'(sfp_pkg::POS_UNIT_LO)) begin
        view.b19 = step.data;
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    fld_nxt = view;
    if (step.go) begin
      if (step.last) begin
        pos_nxt = '0;
        fld_nxt = '0;
      end else if (pos_r < PW'(MAX_FRAME)) begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fld_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      fld_r <= fld_nxt;
    end
  end

  assign pos = pos_r;

  position_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_FRAME))
    else $error("byte position beyond frame limit");

  position_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.last |=> pos_r == '0)
    else $error("byte position not cleared after frame end");

endmodule

`default_nettype wire

// ===== design/sfp_weight_parse.sv =====
// running decimal parse of the weight field
`default_nettype none

module sfp_weight_parse #(
  parameter int unsigned PW = 7
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sfp_pkg::step_t step,
  input  wire logic [PW-1:0]  pos,
  output sfp_pkg::weight_t    view
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_STOP
  } phase_t;

  phase_t           phase_r;
  phase_t           phase_v;
  phase_t           phase_nxt;
  sfp_pkg::weight_t wgt_r;
  sfp_pkg::weight_t wgt_nxt;
  logic             in_field;
  logic [7:0]       c;
  logic             is_digit;
  logic             is_space;
  logic [26:0]      acc_step;

  assign in_field = step.go && (pos >= PW'(sfp_pkg::POS_WFIRST))
                    && (pos <= PW'(sfp_pkg::POS_WLAST));
  assign c        = (step.data == sfp_pkg::CH_MINUS) ? sfp_pkg::CH_SPACE : step.data;
  assign is_digit = (c >= sfp_pkg::CH_ZERO) && (c <= sfp_pkg::CH_NINE);
  assign is_space = (c == sfp_pkg::CH_SPACE)
                    || ((c >= sfp_pkg::CH_TAB) && (c <= sfp_pkg::CH_CR));
  assign acc_step = (wgt_r.acc << 3) + (wgt_r.acc << 1)
                    + sfp_pkg::ACC_W'(c - sfp_pkg::CH_ZERO);

  always_comb begin
    view    = wgt_r;
    phase_v = phase_r;
    if (in_field) begin
      if (step.data == sfp_pkg::CH_DOT) begin
        view.point = 3'(PW'(sfp_pkg::POS_WLAST) - pos);
      end else begin
        if (step.data == sfp_pkg::CH_MINUS) begin
          view.minus = 1'b1;
        end
        unique case (phase_r)
          PH_SKIP: begin
            if (is_space) begin
              phase_v = PH_SKIP;
            end else if (c == sfp_pkg::CH_PLUS) begin
              phase_v = PH_DIGITS;
            end else if (is_digit) begin
              view.acc = acc_step;
              phase_v  = PH_DIGITS;
            end else begin
              phase_v = PH_STOP;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              view.acc = acc_step;
            end else begin
              phase_v = PH_STOP;
            end
          end
          default: begin
            phase_v = PH_STOP;
          end
        endcase
      end
    end
  end

  always_comb begin
    phase_nxt = phase_v;
    wgt_nxt   = view;
    if (step.go && step.last) begin
      phase_nxt = PH_SKIP;
      wgt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      wgt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      wgt_r   <= wgt_nxt;
    end
  end

  stopped_stays: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP && !(step.go && step.last) |=> phase_r == PH_STOP)
    else $error("weight parse resumed after stop");

endmodule

`default_nettype wire

// ===== design/sfp_report.sv =====
// report field decode, kept values and result register
`default_nettype none

module sfp_report (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             frame_done,
  input  wire sfp_pkg::fields_t fld,
  input  wire sfp_pkg::weight_t wgt,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output sfp_pkg::out_item_t    out_item
);

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  sfp_pkg::out_item_t    out_r;
  sfp_pkg::out_item_t    out_nxt;
  logic [1:0]            stab_r;
  logic [1:0]            stab_nxt;
  logic                  gn_r;
  logic                  gn_nxt;
  logic                  unit_r;
  logic                  unit_nxt;
  logic [7:0]            dev_r;
  logic [7:0]            dev_nxt;
  logic signed [27:0]    wval_r;
  logic signed [27:0]    wval_nxt;
  logic [2:0]            point_r;
  logic [2:0]            point_nxt;
  logic                  kind;
  logic [27:0]           mag;

  assign mag = sfp_pkg::WGT_W'(wgt.acc);

  always_comb begin
    kind      = sfp_pkg::KIND_REPORT;
    stab_nxt  = stab_r;
    gn_nxt    = gn_r;
    unit_nxt  = unit_r;
    dev_nxt   = dev_r;
    wval_nxt  = wval_r;
    point_nxt = point_r;
    if (fld.head[0] == sfp_pkg::CH_U && fld.head[1] == sfp_pkg::CH_S) begin
      stab_nxt = sfp_pkg::STAB_UNSTABLE;
    end else if (fld.head[0] == sfp_pkg::CH_S && fld.head[1] == sfp_pkg::CH_T) begin
      stab_nxt = sfp_pkg::STAB_STABLE;
    end else if (fld.head[0] == sfp_pkg::CH_O && fld.head[1] == sfp_pkg::CH_L) begin
      stab_nxt = sfp_pkg::STAB_OVERLOAD;
    end else if (fld.head[0] == sfp_pkg::CH_S && fld.head[1] == sfp_pkg::CH_E
                 && fld.head[2] == sfp_pkg::CH_T) begin
      kind = sfp_pkg::KIND_SETTINGS;
    end
    if (kind == sfp_pkg::KIND_REPORT) begin
      if (fld.head[3] == sfp_pkg::CH_G && fld.head[4] == sfp_pkg::CH_S) begin
        gn_nxt = sfp_pkg::GN_GROSS;
      end else if (fld.head[3] == sfp_pkg::CH_N && fld.head[4] == sfp_pkg::CH_T) begin
        gn_nxt = sfp_pkg::GN_NET;
      end
      dev_nxt   = fld.b6 - sfp_pkg::CH_ZERO;
      point_nxt = wgt.point;
      wval_nxt  = wgt.minus ? $signed(28'd0 - mag) : $signed(mag);
      if (fld.b19 == sfp_pkg::CH_LOW_G) begin
        if (fld.b18 == sfp_pkg::CH_LOW_K) begin
          unit_nxt = sfp_pkg::UNIT_KG;
        end
      end else if (fld.b19 == sfp_pkg::CH_LOW_T) begin
        unit_nxt = sfp_pkg::UNIT_TON;
      end
    end
  end

  always_comb begin
    out_nxt                = out_r;
    out_valid_nxt          = out_valid_r && !out_ready;
    if (frame_done) begin
      out_valid_nxt          = 1'b1;
      out_nxt.frame_kind     = kind;
      out_nxt.stability      = stab_nxt;
      out_nxt.gross_net      = gn_nxt;
      out_nxt.weight_unit    = unit_nxt;
      out_nxt.device_number  = dev_nxt;
      out_nxt.weight_value   = wval_nxt;
      out_nxt.point_position = point_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      stab_r      <= sfp_pkg::STAB_UNSTABLE;
      gn_r        <= sfp_pkg::GN_GROSS;
      unit_r      <= sfp_pkg::UNIT_KG;
      dev_r       <= '0;
      wval_r      <= '0;
      point_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (frame_done) begin
        stab_r  <= stab_nxt;
        gn_r    <= gn_nxt;
        unit_r  <= unit_nxt;
        dev_r   <= dev_nxt;
        wval_r  <= wval_nxt;
        point_r <= point_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> !out_valid_r || out_ready)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== design/scale_frame_parser_core.sv =====
// top level of the scale report frame parser
// a frame-end item is held in the input register, then decoded into the result register
// as it leaves the input register
// throughput: one item per cycle; a frame-end item waits in the input register
// while the previous result has not been taken
// reset: synchronous, clears position, captured bytes, parse state and kept values
`default_nettype none

module scale_frame_parser_core #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sfp_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sfp_pkg::out_item_t       out_item
);

  localparam int unsigned PW = $clog2(MAX_FRAME + 1);

  sfp_pkg::in_item_t in_r;
  logic              in_v_r;
  logic              in_v_nxt;
  logic              take;
  logic              advance;
  sfp_pkg::step_t    step;
  logic [PW-1:0]     pos;
  sfp_pkg::fields_t  fld;
  sfp_pkg::weight_t  wgt;

  assign advance  = in_v_r && (!in_r.frame_end || !out_valid || out_ready);
  assign in_ready = !in_v_r || advance;
  assign take     = in_valid && in_ready;
  assign in_v_nxt = take || (in_v_r && !advance);

  assign step.go   = advance;
  assign step.last = in_r.frame_end;
  assign step.data = in_r.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r <= in_item;
    end
  end

  sfp_field_capture #(
    .MAX_FRAME (MAX_FRAME),
    .PW        (PW)
  ) u_capture (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .pos   (pos),
    .view  (fld)
  );

  sfp_weight_parse #(
    .PW (PW)
  ) u_weight (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .pos   (pos),
    .view  (wgt)
  );

  sfp_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (advance && in_r.frame_end),
    .fld        (fld),
    .wgt        (wgt),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  frame_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.frame_end |=> out_valid)
    else $error("frame end produced no result");

  stall_only_on_pending_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && in_r.frame_end && out_valid && !out_ready)
    else $error("input stalled without a pending result");

  reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_v_r)
    else $error("item held across reset");

endmodule

`default_nettype wire
